// ===== rtl/core/ssp_pkg.sv =====
package ssp_pkg;

	// CORDIC configuration
	localparam int CORDIC_STAGES = 32;
	localparam int ATAN_LEN = 40;
	localparam int CORDIC_N = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

	// datapath width of CORDIC x/y (and rotation z)
	localparam int CW = 34;

	// angle constants in binary turns, then the CORDIC gain constants
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [31:0] HALF_TURN = 32'h8000_0000;
	localparam logic [31:0] OBLIQUITY_TURNS = 32'd279657156;
	localparam logic [31:0] INV_GAIN = 32'd2608131496;
	localparam logic signed [63:0] ROT_START = 64'sd652032874;

	// sidereal unit latency, counted in register stages
	localparam int SID_LAT = 7;

	typedef logic signed [CW-1:0] cord_t;

	typedef struct packed {
		logic [31:0] unix_seconds;
		logic [31:0] sun_longitude;
	} ssp_in_t;

	typedef struct packed {
		logic signed [31:0] subsolar_longitude;
		logic signed [31:0] subsolar_latitude;
	} ssp_out_t;

	typedef struct packed {
		logic signed [63:0] c;
		logic signed [63:0] s;
	} cs64_t;

	// atan(2^-i) in turns
	function automatic logic [31:0] atan_turns(input int i);
		logic [31:0] v;
		case (i)
			0: v = 32'd536870912;
			1: v = 32'd316933406;
			2: v = 32'd167458907;
			3: v = 32'd85004756;
			4: v = 32'd42667331;
			5: v = 32'd21354465;
			6: v = 32'd10679838;
			7: v = 32'd5340245;
			8: v = 32'd2670163;
			9: v = 32'd1335087;
			10: v = 32'd667544;
			11: v = 32'd333772;
			12: v = 32'd166886;
			13: v = 32'd83443;
			14: v = 32'd41722;
			15: v = 32'd20861;
			16: v = 32'd10430;
			17: v = 32'd5215;
			18: v = 32'd2608;
			19: v = 32'd1304;
			20: v = 32'd652;
			21: v = 32'd326;
			22: v = 32'd163;
			23: v = 32'd81;
			24: v = 32'd41;
			25: v = 32'd20;
			26: v = 32'd10;
			27: v = 32'd5;
			28: v = 32'd3;
			29: v = 32'd1;
			30: v = 32'd1;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

	// same table, widened for the rotation z path
	function automatic cord_t atan_cw(input int i);
		return $signed({{(CW-32){1'b0}}, atan_turns(i)});
	endfunction

	// shift-subtract division, elaboration use only
	function automatic logic [127:0] udiv128(input logic [127:0] num, input logic [127:0] den);
		logic [127:0] q;
		logic [128:0] r;
		q = '0;
		r = '0;
		for (int i = 127; i >= 0; i--) begin
			r = {r[127:0], num[i]};
			if (r >= {1'b0, den}) begin
				r = r - {1'b0, den};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// rotation CORDIC on a constant angle
	function automatic cs64_t cordic_const(input logic [31:0] ang);
		logic [31:0] a;
		logic flip;
		logic signed [63:0] x, y, z, dx, dy;
		cs64_t r;
		a = ang;
		flip = 1'b0;
		if (((a + QUARTER_TURN) & HALF_TURN) != '0) begin
			a = a + HALF_TURN;
			flip = 1'b1;
		end
		x = ROT_START;
		y = '0;
		z = $signed({{32{a[31]}}, a});
		for (int i = 0; i < CORDIC_N; i++) begin
			dx = x >>> i;
			dy = y >>> i;
			if (z >= 0) begin
				x = x - dy;
				y = y + dx;
				z = z - $signed({32'd0, atan_turns(i)});
			end else begin
				x = x + dy;
				y = y - dx;
				z = z + $signed({32'd0, atan_turns(i)});
			end
		end
		r.c = flip ? -x : x;
		r.s = flip ? -y : y;
		return r;
	endfunction

	localparam cs64_t OBL_CS = cordic_const(OBLIQUITY_TURNS);
	localparam logic signed [CW-1:0] COS_E = OBL_CS.c[CW-1:0];
	localparam logic signed [CW-1:0] SIN_E = OBL_CS.s[CW-1:0];

	// floor(2^48 / 86400): day estimate, low by at most one
	localparam logic [127:0] DAY_RECIP_W = udiv128(128'd1 << 48, 128'd86400);
	localparam logic [31:0] DAY_RECIP = DAY_RECIP_W[31:0];

	// sidereal offset at J2000, rounded
	localparam logic [127:0] T1_W =
		udiv128((128'd6697374558 << 33) + 128'd24000000000, 128'd48000000000);
	localparam logic [31:0] T1_TURNS = T1_W[31:0];

	// per half day rate term, 48 fraction bits; the constant spans 71 bits
	localparam logic [127:0] GQ =
		udiv128((128'd2400051336 << 80) + 128'd1753199999999, 128'd1753200000000);
	localparam logic [29:0] G_LO = GQ[29:0];
	localparam logic [40:0] G_HI = GQ[70:30];

	// seconds of day term, 50 fraction bits
	localparam logic [127:0] FQ =
		udiv128((128'd1002737909 << 82) + 128'd86399999999999, 128'd86400000000000);
	localparam logic [32:0] F_LO = FQ[32:0];
	localparam logic [32:0] F_HI = FQ[65:33];

	// quadratic term, 90 fraction bits
	localparam logic [127:0] HQ =
		udiv128((128'd12931 << 111) + 128'd31267397460937499, 128'd31267397460937500);
	localparam logic [23:0] H_0 = HQ[23:0];
	localparam logic [23:0] H_1 = HQ[47:24];
	localparam logic [23:0] H_2 = HQ[71:48];

endpackage

// ===== rtl/core/ssp_vector.sv =====
// Unrolled vectoring CORDIC: angle and scaled magnitude of (x, y).
// CORDIC_N + 1 register stages (a fold, then the micro-rotations), advancing when en is high.
module ssp_vector import ssp_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  cord_t       x_in,
	input  cord_t       y_in,
	output cord_t       mag,
	output logic [31:0] ang
);

	cord_t x_s [0:CORDIC_N];
	cord_t y_s [0:CORDIC_N];
	logic [31:0] z_s [0:CORDIC_N];

	// fold left half plane by a half turn
	always_ff @(posedge clk) begin
		if (en) begin
			if (x_in < 0) begin
				x_s[0] <= -x_in;
				y_s[0] <= -y_in;
				z_s[0] <= HALF_TURN;
			end else begin
				x_s[0] <= x_in;
				y_s[0] <= y_in;
				z_s[0] <= '0;
			end
		end
	end

	// micro-rotations toward y = 0
	for (genvar i = 0; i < CORDIC_N; i++) begin : g_stage
		always_ff @(posedge clk) begin
			if (en) begin
				if (y_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_turns(i);
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_turns(i);
				end
			end
		end
	end

	assign mag = x_s[CORDIC_N];
	assign ang = z_s[CORDIC_N];

endmodule

// ===== rtl/core/ssp_sidereal.sv =====
// Greenwich mean sidereal angle from Unix seconds, SID_LAT stages.
module ssp_sidereal import ssp_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] secs,
	output logic [31:0] sid
);

	localparam logic [16:0] SEC_PER_DAY = 17'd86400;
	localparam logic signed [17:0] J2000_HALF_DAYS = 18'sd21915;

	logic [31:0] secs_s1;
	logic [63:0] dprod_s1;
	logic [15:0] day_s2;
	logic [17:0] rem_s2;
	logic signed [17:0] n_s3;
	logic [16:0] sod_s3;
	logic signed [48:0] t2l_s4;
	logic signed [59:0] t2h_s4;
	logic [49:0] t4l_s4;
	logic [49:0] t4h_s4;
	logic [32:0] nsq_s4;
	logic [31:0] t2_s5;
	logic [31:0] t4_s5;
	logic [56:0] q0_s5;
	logic [56:0] q1_s5;
	logic [56:0] q2_s5;
	logic [31:0] t124_s6;
	logic [12:0] t3_s6;
	logic [31:0] sid_s7;

	logic [15:0] day_est;
	logic [32:0] rem_c;
	logic [15:0] day_c;
	logic [16:0] sod_c;
	logic signed [35:0] nsq_c;
	logic [79:0] t2_sum;
	logic [81:0] t4_sum;
	logic [105:0] t3_sum;

	// day split: reciprocal estimate and remainder
	always_comb begin
		day_est = dprod_s1[63:48];
		rem_c = {1'b0, secs_s1} - (33'(day_est) * 33'(SEC_PER_DAY));
	end

	// one-step correction of the estimate
	always_comb begin
		if (rem_s2 >= {1'b0, SEC_PER_DAY}) begin
			day_c = day_s2 + 16'd1;
			sod_c = 17'(rem_s2 - {1'b0, SEC_PER_DAY});
		end else begin
			day_c = day_s2;
			sod_c = rem_s2[16:0];
		end
	end

	// term sums with round half up
	always_comb begin
		nsq_c = n_s3 * n_s3;
		t2_sum = 80'(t2l_s4) + (80'(t2h_s4) << 30) + (80'd1 << 47);
		t4_sum = 82'(t4l_s4) + (82'(t4h_s4) << 33) + (82'd1 << 49);
		t3_sum = 106'(q0_s5) + (106'(q1_s5) << 24) + (106'(q2_s5) << 48) + (106'd1 << 89);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			secs_s1 <= secs;
			dprod_s1 <= secs * DAY_RECIP;
			day_s2 <= day_est;
			rem_s2 <= rem_c[17:0];
			n_s3 <= $signed({1'b0, day_c, 1'b0}) - J2000_HALF_DAYS;
			sod_s3 <= sod_c;
			t2l_s4 <= n_s3 * $signed({1'b0, G_LO});
			t2h_s4 <= n_s3 * $signed({1'b0, G_HI});
			t4l_s4 <= sod_s3 * F_LO;
			t4h_s4 <= sod_s3 * F_HI;
			nsq_s4 <= nsq_c[32:0];
			t2_s5 <= t2_sum[79:48];
			t4_s5 <= t4_sum[81:50];
			q0_s5 <= nsq_s4 * H_0;
			q1_s5 <= nsq_s4 * H_1;
			q2_s5 <= nsq_s4 * H_2;
			t124_s6 <= T1_TURNS + t2_s5 + t4_s5;
			t3_s6 <= t3_sum[102:90];
			sid_s7 <= t124_s6 + {19'd0, t3_s6};
		end
	end

	assign sid = sid_s7;

endmodule

// ===== rtl/core/subsolar_point.sv =====
// Subsolar point: each word carries a Unix time and the sun's ecliptic longitude and
// yields the longitude and latitude (binary turns) of the point with the sun at zenith.
// Fully pipelined: one word per cycle, through three chained unrolled CORDIC units
// (rotation, then two vectoring passes) plus multiply and rounding stages; the
// sidereal angle runs in parallel. When a result is held at the output, the whole
// pipeline holds with it. No reset sweep; the block is ready right after reset.
module subsolar_point import ssp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	input  ssp_in_t  item,
	output logic     result_valid,
	input  logic     result_ready,
	output ssp_out_t result
);

	localparam int LAT = 7 + 3 * CORDIC_N;
	localparam int V1_OUT = 4 + 2 * CORDIC_N;
	localparam int V2_IN = 5 + 2 * CORDIC_N;
	localparam int SD = V1_OUT - SID_LAT;
	localparam logic signed [2*CW-1:0] ROUND_Q30 = {{(2*CW-30){1'b0}}, 1'b1, 29'd0};
	localparam logic [64:0] ROUND_32 = 65'd1 << 31;
	localparam logic signed [31:0] LAT_MAX = 32'sh4000_0000;
	localparam logic signed [31:0] LAT_MIN = -32'sh4000_0000;

	logic en;
	logic accept;
	logic [LAT:1] vld_s;

	// global advance: the pipe moves unless the output word is held
	assign en = !vld_s[LAT] || result_ready;
	assign item_ready = en;
	assign accept = item_valid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-1:1], accept};
		end
	end

	// rotation input fold
	logic [31:0] lam_a;
	logic lam_flip;
	always_comb begin
		lam_flip = ((item.sun_longitude + QUARTER_TURN) & HALF_TURN) != '0;
		lam_a = lam_flip ? item.sun_longitude + HALF_TURN : item.sun_longitude;
	end

	cord_t rx_s [0:CORDIC_N];
	cord_t ry_s [0:CORDIC_N];
	cord_t rz_s [0:CORDIC_N];
	logic [0:CORDIC_N] rflip_s;

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s[0] <= cord_t'(ROT_START);
			ry_s[0] <= '0;
			rz_s[0] <= $signed({{(CW-32){lam_a[31]}}, lam_a});
			rflip_s[0] <= lam_flip;
		end
	end

	// rotation micro-steps: cos and sin of the ecliptic longitude
	for (genvar i = 0; i < CORDIC_N; i++) begin : g_rot
		always_ff @(posedge clk) begin
			if (en) begin
				rflip_s[i+1] <= rflip_s[i];
				if (rz_s[i] >= 0) begin
					rx_s[i+1] <= rx_s[i] - (ry_s[i] >>> i);
					ry_s[i+1] <= ry_s[i] + (rx_s[i] >>> i);
					rz_s[i+1] <= rz_s[i] - atan_cw(i);
				end else begin
					rx_s[i+1] <= rx_s[i] + (ry_s[i] >>> i);
					ry_s[i+1] <= ry_s[i] - (rx_s[i] >>> i);
					rz_s[i+1] <= rz_s[i] + atan_cw(i);
				end
			end
		end
	end

	// undo the fold, then scale sin(l) by cos(e) and sin(e)
	cord_t cl_s, sl_s, cl2_s;
	logic signed [2*CW-1:0] pc_s, ps_s;

	always_ff @(posedge clk) begin
		if (en) begin
			cl_s <= rflip_s[CORDIC_N] ? -rx_s[CORDIC_N] : rx_s[CORDIC_N];
			sl_s <= rflip_s[CORDIC_N] ? -ry_s[CORDIC_N] : ry_s[CORDIC_N];
			cl2_s <= cl_s;
			pc_s <= sl_s * COS_E;
			ps_s <= sl_s * SIN_E;
		end
	end

	// Q30 rounding of both products
	logic signed [2*CW-1:0] pc_r, ps_r;
	always_comb begin
		pc_r = (pc_s + ROUND_Q30) >>> 30;
		ps_r = (ps_s + ROUND_Q30) >>> 30;
	end

	// right ascension and cos(dec) magnitude
	cord_t mag1;
	logic [31:0] ang1;
	ssp_vector u_vec_ra (
		.clk  (clk),
		.en   (en),
		.x_in (cl2_s),
		.y_in (pc_r[CW-1:0]),
		.mag  (mag1),
		.ang  (ang1)
	);

	// sin(e) sin(l) waits for the second vectoring pass
	cord_t pd_s [0:CORDIC_N+1];
	always_ff @(posedge clk) begin
		if (en) begin
			pd_s[0] <= ps_r[CW-1:0];
			for (int k = 1; k <= CORDIC_N + 1; k++) begin
				pd_s[k] <= pd_s[k-1];
			end
		end
	end

	// sidereal angle, delayed to meet right ascension
	logic [31:0] sid_w;
	logic [31:0] sd_s [1:SD];
	ssp_sidereal u_sidereal (
		.clk  (clk),
		.en   (en),
		.secs (item.unix_seconds),
		.sid  (sid_w)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s[1] <= sid_w;
			for (int k = 2; k <= SD; k++) begin
				sd_s[k] <= sd_s[k-1];
			end
		end
	end

	// gain correction of magnitude, longitude difference
	logic [CW-2:0] kmag;
	logic [64:0] gprod_s;
	logic [31:0] lon_s;
	logic [31:0] ld_s [1:CORDIC_N+1];

	assign kmag = mag1[CW-1] ? '0 : mag1[CW-2:0];

	always_ff @(posedge clk) begin
		if (en) begin
			gprod_s <= kmag * INV_GAIN;
			lon_s <= ang1 - sd_s[SD];
			ld_s[1] <= lon_s;
			for (int k = 2; k <= CORDIC_N + 1; k++) begin
				ld_s[k] <= ld_s[k-1];
			end
		end
	end

	logic [65:0] m_sum;
	cord_t m_c;
	assign m_sum = {1'b0, gprod_s} + {1'b0, ROUND_32};
	assign m_c = m_sum[CW+31:32];

	// declination
	cord_t mag2;
	logic [31:0] ang2;
	ssp_vector u_vec_dec (
		.clk  (clk),
		.en   (en),
		.x_in (m_c),
		.y_in (pd_s[CORDIC_N+1]),
		.mag  (mag2),
		.ang  (ang2)
	);

	// latitude clamp into the output word
	logic signed [31:0] dec;
	logic signed [31:0] lat_c;
	logic signed [CW-1:0] mag2_unused;
	assign mag2_unused = mag2;
	always_comb begin
		dec = $signed(ang2);
		priority if (dec > LAT_MAX) begin
			lat_c = LAT_MAX;
		end else if (dec < LAT_MIN) begin
			lat_c = LAT_MIN;
		end else begin
			lat_c = dec;
		end
	end

	ssp_out_t res_s;
	always_ff @(posedge clk) begin
		if (en) begin
			res_s.subsolar_longitude <= $signed(ld_s[CORDIC_N+1]);
			res_s.subsolar_latitude <= lat_c;
		end
	end

	assign result_valid = vld_s[LAT];
	assign result = res_s;

	// held output freezes every stage's valid bit
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=> $stable(vld_s))
		else $error("pipeline moved while output was held");

	// right ascension vectoring magnitude never goes negative
	a_mag_pos: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[V1_OUT] |-> !mag1[CW-1])
		else $error("negative ra vectoring magnitude");

	// cos(dec) into the second pass is non-negative
	a_m_pos: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[V2_IN] |-> !m_c[CW-1])
		else $error("negative cos(dec) operand");

	// latitude stays within a quarter turn
	a_lat_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.subsolar_latitude <= LAT_MAX &&
			result.subsolar_latitude >= LAT_MIN))
		else $error("latitude out of range");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import ssp_pkg::*;

	localparam int PIPE_CYCLES = 7 + 3 * CORDIC_N;
	localparam int STALL_LIMIT = 20000;
	localparam int RANDOM_WORDS = 1850;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	ssp_in_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	ssp_out_t result;

	// idle percentages, changed per phase
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_off = 1'b0;

	int mismatches = 0;
	int quiet_cycles = 0;
	ssp_out_t expected_points[$];

	// arctangent of 2^-i in binary turns
	localparam logic [31:0] ARCTAN_TURNS [0:39] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
		32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1,
		32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0
	};

	subsolar_point i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always #5 clk = ~clk;

	// sine and cosine of an angle, Q30
	function automatic void rotate_angle(input logic [31:0] ang, output longint cosv,
			output longint sinv);
		logic [31:0] a;
		bit flip;
		longint x, y, z, dx, dy;
		a = ang;
		flip = 1'b0;
		if (((a + QUARTER_TURN) & HALF_TURN) != 0) begin
			a = a + HALF_TURN;
			flip = 1'b1;
		end
		x = 652032874;
		y = 0;
		z = longint'($signed(a));
		for (int i = 0; i < CORDIC_N; i++) begin
			dx = x >>> i;
			dy = y >>> i;
			if (z >= 0) begin
				x = x - dy; y = y + dx; z = z - longint'(ARCTAN_TURNS[i]);
			end else begin
				x = x + dy; y = y - dx; z = z + longint'(ARCTAN_TURNS[i]);
			end
		end
		cosv = flip ? -x : x;
		sinv = flip ? -y : y;
	endfunction

	// angle and scaled magnitude of a vector
	function automatic void vector_angle(input longint xin, input longint yin,
			output logic [31:0] ang, output longint mag);
		longint x, y, dx, dy;
		x = xin;
		y = yin;
		ang = 32'd0;
		if (x < 0) begin
			x = -x; y = -y; ang = HALF_TURN;
		end
		for (int i = 0; i < CORDIC_N; i++) begin
			dx = x >>> i;
			dy = y >>> i;
			if (y >= 0) begin
				x = x + dy; y = y - dx; ang = ang + ARCTAN_TURNS[i];
			end else begin
				x = x - dy; y = y + dx; ang = ang - ARCTAN_TURNS[i];
			end
		end
		mag = x;
	endfunction

	function automatic longint q30_product(longint a, longint b);
		return (a * b + (longint'(1) << 29)) >>> 30;
	endfunction

	// rounded num * 2^shift / den
	function automatic longint unsigned round_ratio(longint unsigned num, int shift,
			longint unsigned den);
		longint unsigned q, r;
		q = num / den;
		r = num % den;
		for (int k = 0; k < shift; k++) begin
			q = q << 1;
			r = r << 1;
			if (r >= den) begin
				r = r - den;
				q = q + 1;
			end
		end
		if (2 * r >= den)
			q = q + 1;
		return q;
	endfunction

	function automatic logic [31:0] fraction_turns(longint num, longint unsigned den);
		longint unsigned r;
		if (num >= 0) begin
			r = longint'(num) % den;
		end else begin
			r = longint'(-num) % den;
			if (r != 0)
				r = den - r;
		end
		return 32'(round_ratio(r, 32, den));
	endfunction

	// Greenwich mean sidereal angle in turns
	function automatic logic [31:0] sidereal_angle(logic [31:0] secs);
		logic [31:0] day, sod, t1, t2, t3, t4;
		longint n;
		day = secs / 32'd86400;
		sod = secs % 32'd86400;
		n = 2 * longint'(day) - 21915;
		t1 = 32'(round_ratio(64'd6697374558, 32, 64'd24000000000));
		t2 = fraction_turns(64'sd2400051336 * n, 64'd1753200000000);
		t3 = 32'(round_ratio(64'd12931 * longint'(n * n), 21, 64'd31267397460937500));
		t4 = 32'(round_ratio(longint'(sod) * 64'd1002737909, 32, 64'd86400000000000));
		return t1 + t2 + t3 + t4;
	endfunction

	function automatic ssp_out_t subsolar_of(ssp_in_t w);
		longint ce, se, cl, sl, kmag, m, unused, lat;
		logic [31:0] ra, dec;
		ssp_out_t p;
		rotate_angle(OBLIQUITY_TURNS, ce, se);
		rotate_angle(w.sun_longitude, cl, sl);
		vector_angle(cl, q30_product(sl, ce), ra, kmag);
		if (kmag < 0)
			kmag = 0;
		m = longint'((longint'(kmag) * 64'd2608131496 + 64'h8000_0000) >> 32);
		vector_angle(m, q30_product(sl, se), dec, unused);
		lat = longint'($signed(dec));
		if (lat > longint'(QUARTER_TURN))
			lat = longint'(QUARTER_TURN);
		if (lat < -longint'(QUARTER_TURN))
			lat = -longint'(QUARTER_TURN);
		p.subsolar_longitude = ra - sidereal_angle(w.unix_seconds);
		p.subsolar_latitude = lat[31:0];
		return p;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %0d, want %0d at %0t", what, $signed(got), $signed(want),
			$realtime);
		mismatches++;
	endtask

	// predict on accepted words, compare on delivered results
	always @(posedge clk) begin
		ssp_out_t want;
		if (arst_n) begin
			if (item_valid && item_ready)
				expected_points.push_back(subsolar_of(item));
			if (result_valid && result_ready) begin
				if (expected_points.size() == 0) begin
					$display("unexpected result word at %0t", $realtime);
					mismatches++;
				end else begin
					want = expected_points.pop_front();
					if (result.subsolar_longitude !== want.subsolar_longitude)
						report_mismatch("longitude", result.subsolar_longitude,
							want.subsolar_longitude);
					if (result.subsolar_latitude !== want.subsolar_latitude)
						report_mismatch("latitude", result.subsolar_latitude,
							want.subsolar_latitude);
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// receiver backpressure
	always @(negedge clk) begin
		result_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic send_word(input ssp_in_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= w;
		do
			@(posedge clk);
		while (!item_ready);
		@(negedge clk);
	endtask

	function automatic logic [31:0] random_word();
		case ($urandom_range(5))
			0: return $urandom_range(255);
			1: return 32'hFFFF_FFFF - $urandom_range(255);
			2: return 32'h8000_0000 + $urandom_range(511) - 256;
			default: return $urandom;
		endcase
	endfunction

	// directed words: time and angle extremes, quadrant edges, J2000 noon
	ssp_in_t directed_words[] = '{
		'{32'd0, 32'd0},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF},
		'{32'd0, 32'h4000_0000},
		'{32'd0, 32'h8000_0000},
		'{32'd0, 32'hC000_0000},
		'{32'd946728000, 32'd0},
		'{32'd946728000, 32'h2000_0000},
		'{32'd86399, 32'd1},
		'{32'd86400, 32'h7FFF_FFFF},
		'{32'd43200, 32'h3FFF_FFFF},
		'{32'd43200, 32'h4000_0001},
		'{32'h7FFF_FFFF, 32'hBFFF_FFFF},
		'{32'h8000_0000, 32'hC000_0001},
		'{32'hAAAA_AAAA, 32'h5555_5555},
		'{32'h5555_5555, 32'hAAAA_AAAA},
		'{32'd1700000000, 32'h6000_0000},
		'{32'd1700000000, 32'hE000_0000},
		'{32'hFFFF_FFFF, 32'd0},
		'{32'd0, 32'hFFFF_FFFF},
		'{32'd4294880000, 32'h8000_0001}
	};

	initial begin
		ssp_in_t w;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (directed_words[i])
			send_word(directed_words[i]);
		// idle profiles: none, sender, receiver, both; long hold-off in the last
		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = (phase == 1) ? 48 : (phase == 3) ? 30 : 0;
			recv_stall_pct = (phase == 2) ? 48 : (phase == 3) ? 30 : 0;
			if (phase == 3)
				fork
					begin
						hold_off = 1'b1;
						repeat (400) @(negedge clk);
						hold_off = 1'b0;
					end
				join_none
			for (int k = 0; k < RANDOM_WORDS / 4; k++) begin
				w.unix_seconds = random_word();
				w.sun_longitude = random_word();
				send_word(w);
			end
		end
		item_valid <= 1'b0;
		wait (expected_points.size() == 0);
		repeat (PIPE_CYCLES + 20) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
